// ----- hw/rtl/pfc_pkg.sv -----
// ----------------------------------------------------------------------------
// pfc_pkg
// Shared types, codes and symbol helpers for the 6x6 digraph cipher core.
// ----------------------------------------------------------------------------
package pfc_pkg;

    localparam int SIDE  = 6;
    localparam int CELLS = SIDE * SIDE;

    localparam logic [1:0] ACT_KEY_CHAR = 2'd0;
    localparam logic [1:0] ACT_KEY_END  = 2'd1;
    localparam logic [1:0] ACT_ENCRYPT  = 2'd2;
    localparam logic [1:0] ACT_DECRYPT  = 2'd3;

    localparam logic [7:0] CH_LOW_A  = 8'h61;
    localparam logic [7:0] CH_LOW_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A   = 8'h41;
    localparam logic [7:0] CH_UP_Z   = 8'h5A;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CASE_DIFF = 8'd32;
    localparam logic [7:0] LETTERS   = 8'd26;

    localparam logic [5:0] LAST_CELL = 6'(CELLS - 1);
    localparam logic [5:0] NUM_CELLS = 6'(CELLS);
    localparam logic [2:0] LAST_IDX  = 3'(SIDE - 1);

    typedef logic [5:0] t_sym;
    typedef logic [5:0] t_cell;
    typedef logic [2:0] t_coord;

    typedef struct packed {
        logic   ok;
        t_sym   sym;
        t_coord row;
        t_coord col;
    } t_lane_info;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_FILL = 5'b00010,
        ST_LOOK = 5'b00100,
        ST_CELL = 5'b01000,
        ST_DONE = 5'b10000
    } t_state;

    function automatic logic [6:0] char_to_sym(input logic [7:0] ch);
        logic [7:0] c;
        logic [6:0] r;
        c = ch;
        r = '0;
        if (c >= CH_LOW_A && c <= CH_LOW_Z) begin
            c = c - CASE_DIFF;
        end
        if (c >= CH_UP_A && c <= CH_UP_Z) begin
            r = {1'b1, 6'(c - CH_UP_A)};
        end else if (c >= CH_ZERO && c <= CH_NINE) begin
            r = {1'b1, 6'(c - CH_ZERO + LETTERS)};
        end
        return r;
    endfunction

    function automatic logic [7:0] sym_to_char(input t_sym s);
        logic [7:0] w;
        logic [7:0] r;
        w = {2'b00, s};
        r = '0;
        if (w < LETTERS) begin
            r = CH_UP_A + w;
        end else if (w < 8'(CELLS)) begin
            r = CH_ZERO + (w - LETTERS);
        end
        return r;
    endfunction

    function automatic t_coord cell_row(input t_cell c);
        t_coord r;
        r = '0;
        for (int k = 1; k < SIDE; k++) begin
            if (c >= 6'(k * SIDE)) begin
                r = 3'(k);
            end
        end
        return r;
    endfunction

    function automatic t_cell row_base(input t_coord r);
        return 6'({r, 2'b00}) + 6'({r, 1'b0});
    endfunction

    function automatic t_coord step_coord(input t_coord x, input logic dec);
        t_coord r;
        if (dec) begin
            r = (x == '0) ? LAST_IDX : x - 3'd1;
        end else begin
            r = (x == LAST_IDX) ? '0 : x + 3'd1;
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/pfc_lane.sv -----
// ----------------------------------------------------------------------------
// pfc_lane
// One character lane: folds and decodes a character to its symbol index and
// splits the cell read back for that symbol into row and column.
// ----------------------------------------------------------------------------
module pfc_lane (
    input  logic [7:0]          i_char,
    input  pfc_pkg::t_cell      i_place,
    output pfc_pkg::t_lane_info o_info
);
    import pfc_pkg::*;

    logic [6:0] dec;
    t_coord     row;

    always_comb begin
        dec        = char_to_sym(i_char);
        row        = cell_row(i_place);
        o_info.ok  = dec[6];
        o_info.sym = dec[5:0];
        o_info.row = row;
        o_info.col = 3'(i_place - row_base(row));
    end

endmodule

// ----- hw/rtl/pfc_merge.sv -----
// ----------------------------------------------------------------------------
// pfc_merge
// Merge stage: compares the two lanes' coordinates and applies the same-row,
// same-column or rectangle rule to give the two result cells.
// ----------------------------------------------------------------------------
module pfc_merge (
    input  pfc_pkg::t_lane_info i_lane_a,
    input  pfc_pkg::t_lane_info i_lane_b,
    input  logic                i_decrypt,
    output pfc_pkg::t_cell      o_cell_a,
    output pfc_pkg::t_cell      o_cell_b
);
    import pfc_pkg::*;

    t_coord ra, ca, rb, cb;

    always_comb begin
        ra = i_lane_a.row;
        ca = i_lane_a.col;
        rb = i_lane_b.row;
        cb = i_lane_b.col;
        if (i_lane_a.row == i_lane_b.row) begin
            ca = step_coord(i_lane_a.col, i_decrypt);
            cb = step_coord(i_lane_b.col, i_decrypt);
        end else if (i_lane_a.col == i_lane_b.col) begin
            ra = step_coord(i_lane_a.row, i_decrypt);
            rb = step_coord(i_lane_b.row, i_decrypt);
        end else begin
            ca = i_lane_b.col;
            cb = i_lane_a.col;
        end
        o_cell_a = row_base(ra) + 6'(ca);
        o_cell_b = row_base(rb) + 6'(cb);
    end

endmodule

// ----- hw/rtl/playfair_6x6_digraph_cipher_core.sv -----
// ----------------------------------------------------------------------------
// playfair_6x6_digraph_cipher_core
// 6x6 digraph cipher over A-Z and 0-9 with key square build and pair lookup.
// ----------------------------------------------------------------------------
// Input channel i_in_valid / o_in_ready carries one word: an action with up
// to two ASCII characters. Output channel o_out_valid / i_out_ready returns
// exactly one word per input word: two result characters and a bad flag.
// Key characters (action 0) build the square, key end (action 1) fills the
// rest and makes it ready, actions 2 and 3 encrypt or decrypt one pair.
// The key end fill walks the 36 symbols one per cycle and writes each
// symbol not yet in the square into the cell and position memories.
// Pair work: two character lanes read the position memory in the same cycle,
// a merge stage forms the result cells, the cell memory is read next.
// A new word is taken once the last one has reached the output register.
// Reset clears the square state; a new key needs a reset.
// When the receiver stalls, the held result stays in the output register,
// one more word may be accepted and processed, and it waits to load.
// ----------------------------------------------------------------------------
module playfair_6x6_digraph_cipher_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [1:0] i_action,
    input  logic [7:0] i_char_a,
    input  logic [7:0] i_char_b,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [7:0] o_out_a,
    output logic [7:0] o_out_b,
    output logic       o_bad_char
);
    import pfc_pkg::*;

    t_state      r_state, n_state;
    logic [35:0] r_mask, n_mask;
    logic [5:0]  r_fill, n_fill;
    logic [5:0]  r_walk, n_walk;
    logic        r_ready, n_ready;
    logic        r_decrypt, n_decrypt;
    logic        r_out_valid, n_out_valid;

    logic [7:0]  r_res_a, r_res_b;
    logic        r_res_bad;
    logic [7:0]  r_out_a, r_out_b;
    logic        r_out_bad;

    t_sym        r_square [CELLS];
    t_cell       r_place  [CELLS];
    t_cell       r_pa, r_pb;
    t_sym        r_sq_a, r_sq_b;

    t_lane_info  lane_a, lane_b;
    t_cell       cell_a, cell_b;

    logic        accept, out_free;
    logic        wr_en;
    t_sym        wr_sym;
    logic        res_zero, res_bad, res_cell;

    pfc_lane u_lane_a (
        .i_char  (i_char_a),
        .i_place (r_pa),
        .o_info  (lane_a)
    );

    pfc_lane u_lane_b (
        .i_char  (i_char_b),
        .i_place (r_pb),
        .o_info  (lane_b)
    );

    pfc_merge u_merge (
        .i_lane_a  (lane_a),
        .i_lane_b  (lane_b),
        .i_decrypt (r_decrypt),
        .o_cell_a  (cell_a),
        .o_cell_b  (cell_b)
    );

    assign o_in_ready  = (r_state == ST_IDLE);
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_a     = r_out_a;
    assign o_out_b     = r_out_b;
    assign o_bad_char  = r_out_bad;

    always_comb begin
        n_state     = r_state;
        n_mask      = r_mask;
        n_fill      = r_fill;
        n_walk      = r_walk;
        n_ready     = r_ready;
        n_decrypt   = r_decrypt;
        n_out_valid = r_out_valid;
        wr_en       = 1'b0;
        wr_sym      = lane_a.sym;
        res_zero    = 1'b0;
        res_bad     = 1'b0;
        res_cell    = 1'b0;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_decrypt = (i_action == ACT_DECRYPT);
                    case (i_action)
                        ACT_KEY_CHAR: begin
                            res_zero = 1'b1;
                            n_state  = ST_DONE;
                            if (lane_a.ok && !r_ready && !r_mask[lane_a.sym]
                                    && r_fill < NUM_CELLS) begin
                                wr_en = 1'b1;
                            end
                        end
                        ACT_KEY_END: begin
                            n_walk  = '0;
                            n_state = ST_FILL;
                        end
                        default: begin
                            if (!r_ready || !lane_a.ok || !lane_b.ok) begin
                                res_bad = 1'b1;
                                n_state = ST_DONE;
                            end else begin
                                n_state = ST_LOOK;
                            end
                        end
                    endcase
                end
            end
            ST_FILL: begin
                wr_sym = r_walk;
                if (!r_mask[r_walk] && r_fill < NUM_CELLS) begin
                    wr_en = 1'b1;
                end
                n_walk = r_walk + 6'd1;
                if (r_walk == LAST_CELL) begin
                    n_ready  = 1'b1;
                    res_zero = 1'b1;
                    n_state  = ST_DONE;
                end
            end
            ST_LOOK: begin
                n_state = ST_CELL;
            end
            ST_CELL: begin
                res_cell = 1'b1;
                n_state  = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
        if (wr_en) begin
            n_mask[wr_sym] = 1'b1;
            n_fill         = r_fill + 6'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_mask      <= '0;
            r_fill      <= '0;
            r_walk      <= '0;
            r_ready     <= 1'b0;
            r_decrypt   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_mask      <= n_mask;
            r_fill      <= n_fill;
            r_walk      <= n_walk;
            r_ready     <= n_ready;
            r_decrypt   <= n_decrypt;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_square[r_fill] <= wr_sym;
            r_place[wr_sym]  <= r_fill;
        end
        r_pa   <= r_place[lane_a.sym];
        r_pb   <= r_place[lane_b.sym];
        r_sq_a <= r_square[cell_a];
        r_sq_b <= r_square[cell_b];
    end

    always_ff @(posedge i_clk) begin
        if (res_zero || res_bad) begin
            r_res_a   <= '0;
            r_res_b   <= '0;
            r_res_bad <= res_bad;
        end else if (res_cell) begin
            r_res_a   <= sym_to_char(r_sq_a);
            r_res_b   <= sym_to_char(r_sq_b);
            r_res_bad <= 1'b0;
        end
        if (r_state == ST_DONE && out_free) begin
            r_out_a   <= r_res_a;
            r_out_b   <= r_res_b;
            r_out_bad <= r_res_bad;
        end
    end

endmodule
